// ===== sv/doc_length_norm_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// doc length norm encoder assertion macros
// shared concurrent property checks used by the encoder rtl
// ----------------------------------------------------------------------------
`ifndef DOC_LENGTH_NORM_ENCODER_ASSERT_SVH
`define DOC_LENGTH_NORM_ENCODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DLNE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dlne: same-cycle property violated");

// next-cycle implication, disabled during reset
`define DLNE_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dlne: next-cycle property violated");

`endif

// ===== sv/dlne_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlne_pkg
// widths, encoding constants and inter-module types of the norm encoder
// ----------------------------------------------------------------------------
package dlne_pkg;

   // field widths
   localparam int DOC_W    = 12;
   localparam int DOCS_W   = 13;
   localparam int COUNT_W  = 31;
   localparam int TOTAL_W  = 48;
   localparam int NORM_W   = 8;
   localparam int SHIFT_W  = 5;

   // norm encoding constants
   localparam int MANT_BITS = 3;
   localparam int HEAD_BITS = MANT_BITS + 1;
   localparam int MAX_SHIFT = COUNT_W - HEAD_BITS;
   localparam logic [NORM_W-1:0]  FREE_VALUES   = 8'd220;
   localparam logic [COUNT_W-1:0] FREE_VALUES_C = 31'd220;

   // request to the norm unit
   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] count;
   } dlne_norm_req_type;

   // result from the norm unit
   typedef struct packed {
      logic              done;
      logic [NORM_W-1:0] norm;
   } dlne_norm_rsp_type;

endpackage

// ===== sv/dlne_count_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlne_count_mem
// per-document token count store, one write and one registered read port
// ----------------------------------------------------------------------------
module dlne_count_mem
   import dlne_pkg::*;
#(
   parameter  int DEPTH = 4096,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AddrW-1:0]   wr_addr,
   input  logic [COUNT_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AddrW-1:0]   rd_addr,
   output logic [COUNT_W-1:0] rd_data
);

   logic [COUNT_W-1:0] mem_ff [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/dlne_norm_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlne_norm_unit
// iterative length-to-norm-byte encoder, one right shift per cycle
// ----------------------------------------------------------------------------
`include "doc_length_norm_encoder_assert.svh"

module dlne_norm_unit
   import dlne_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dlne_norm_req_type norm_req,
   output dlne_norm_rsp_type norm_rsp
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [NORM_W-1:0]  norm_ff, norm_in;
   logic [COUNT_W-1:0] val_ff, val_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic               above_head;

   // excess still has bits above the mantissa head
   assign above_head = |val_ff[COUNT_W-1:HEAD_BITS];

   // shift until the excess fits in four bits; code = value + 8 * shift
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      norm_in  = norm_ff;
      val_in   = val_ff;
      shift_in = shift_ff;
      if (norm_req.start) begin
         if (norm_req.count == '0) begin
            done_in = 1'b1;
            norm_in = NORM_W'(1);
         end else if (norm_req.count < FREE_VALUES_C) begin
            done_in = 1'b1;
            norm_in = norm_req.count[NORM_W-1:0];
         end else begin
            busy_in  = 1'b1;
            val_in   = norm_req.count - FREE_VALUES_C;
            shift_in = '0;
         end
      end else if (busy_ff) begin
         if (above_head) begin
            val_in   = val_ff >> 1;
            shift_in = shift_ff + SHIFT_W'(1);
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            norm_in = FREE_VALUES + val_ff[NORM_W-1:0] + {shift_ff, 3'b000};
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      norm_ff  <= norm_in;
      val_ff   <= val_in;
      shift_ff <= shift_in;
   end

   assign norm_rsp.done = done_ff;
   assign norm_rsp.norm = norm_ff;

   // checks
   `DLNE_ASSERT_IMP(a_shift_bound, clock, reset, busy_ff, shift_ff <= SHIFT_W'(MAX_SHIFT))
   `DLNE_ASSERT_IMP(a_no_start_busy, clock, reset, norm_req.start, !busy_ff)
   `DLNE_ASSERT_NXT(a_done_pulse, clock, reset, done_ff, !done_ff)

endmodule

// ===== sv/doc_length_norm_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doc_length_norm_encoder
// per-document token counter with length norm byte readout
// ----------------------------------------------------------------------------
// usage: requests enter on req_* (tuser = func, tdata = doc_number). func 0
// records one token of a document, func 1 reads that document's norm byte.
// every request gives exactly one response on rsp_* with the norm byte, the
// running token total and the document count; rsp_tuser flags a read beyond
// the document count or a record beyond the store.
// sequence: a record, or a read beyond the document count, passes through
// FETCH, EXEC and FIN; any other read passes through FETCH, EXEC, NORM and
// FIN and waits in NORM until the norm unit is done; the loop in the norm unit
// sets the read cost. req_tready is high only in IDLE, entered as FIN places
// the response in the output register, so one request is worked at a time.
// reset: the count store is swept to zero, one entry per cycle, over all
// min(MAX_DOCS, 4096) entries; req_tready stays low meanwhile.
// stall: a held response keeps rsp_tdata stable; one more request can be
// accepted and worked while it waits, then the block holds until rsp_tready.
// ----------------------------------------------------------------------------
`include "doc_length_norm_encoder_assert.svh"

module doc_length_norm_encoder
   import dlne_pkg::*;
#(
   parameter int MAX_DOCS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] doc_number, [15:12] zero
   input  logic        req_tuser,   // [0] func
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [7:0] norm_byte, [55:8] token_total,
                                    // [68:56] doc_total, [71:69] zero
   output logic        rsp_tuser    // [0] status
);

   localparam int Depth = (MAX_DOCS < (1 << DOC_W)) ? MAX_DOCS : (1 << DOC_W);
   localparam int AddrW = $clog2(Depth);
   localparam logic [DOCS_W-1:0] DepthVal = DOCS_W'(Depth);
   localparam logic [AddrW-1:0]  AddrLast = AddrW'(Depth - 1);
   localparam int RspPadW = 72 - NORM_W - TOTAL_W - DOCS_W;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_FETCH = 6'b000100,
      ST_EXEC  = 6'b001000,
      ST_NORM  = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [AddrW-1:0]   clear_ff, clear_in;
   logic [DOCS_W-1:0]  docs_seen_ff, docs_seen_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               func_ff, func_in;
   logic [DOC_W-1:0]   doc_ff, doc_in;
   logic [NORM_W-1:0]  norm_ff, norm_in;
   logic               status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [71:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   logic               wr_en;
   logic [AddrW-1:0]   wr_addr;
   logic [COUNT_W-1:0] wr_data;
   logic               rd_en;
   logic [COUNT_W-1:0] rd_data;
   logic [DOCS_W-1:0]  doc_wide;
   logic [DOCS_W-1:0]  doc_next;
   logic               req_fire;
   logic               rsp_fire;
   logic               out_free;
   dlne_norm_req_type  norm_req;
   dlne_norm_rsp_type  norm_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign doc_wide   = {1'b0, doc_ff};
   assign doc_next   = doc_wide + DOCS_W'(1);

   // count store
   dlne_count_mem #(
      .DEPTH (Depth)
   ) u_count_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (doc_ff[AddrW-1:0]),
      .rd_data (rd_data)
   );

   // norm encoder for reads
   dlne_norm_unit u_norm_unit (
      .clock    (clock),
      .reset    (reset),
      .norm_req (norm_req),
      .norm_rsp (norm_rsp)
   );

   // store ports: read in FETCH, clearing sweep or count write-back
   always_comb begin
      rd_en   = (state_ff == ST_FETCH);
      wr_en   = 1'b0;
      wr_addr = doc_ff[AddrW-1:0];
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clear_ff;
      end else if (state_ff == ST_EXEC && !func_ff && doc_wide < DepthVal) begin
         wr_en   = 1'b1;
         wr_data = (&rd_data) ? rd_data : rd_data + COUNT_W'(1);
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clear_in       = clear_ff;
      docs_seen_in   = docs_seen_ff;
      total_in       = total_ff;
      func_in        = func_ff;
      doc_in         = doc_ff;
      norm_in        = norm_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      norm_req.start = 1'b0;
      norm_req.count = rd_data;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + AddrW'(1);
            if (clear_ff == AddrLast) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               func_in  = req_tuser;
               doc_in   = req_tdata[DOC_W-1:0];
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            norm_in = '0;
            if (!func_ff) begin
               // record one token
               if (doc_wide < DepthVal) begin
                  status_in = 1'b0;
                  if (!(&total_ff)) begin
                     total_in = total_ff + TOTAL_W'(1);
                  end
                  if (doc_next > docs_seen_ff) begin
                     docs_seen_in = doc_next;
                  end
               end else begin
                  status_in = 1'b1;
               end
               state_in = ST_FIN;
            end else if (doc_wide >= docs_seen_ff) begin
               // read beyond the document count
               status_in = 1'b1;
               state_in  = ST_FIN;
            end else begin
               status_in      = 1'b0;
               norm_req.start = 1'b1;
               state_in       = ST_NORM;
            end
         end
         ST_NORM: begin
            if (norm_rsp.done) begin
               norm_in  = norm_rsp.norm;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {RspPadW'(0), docs_seen_ff, total_ff, norm_ff};
               rsp_user_in  = status_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         docs_seen_ff <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         docs_seen_ff <= docs_seen_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      doc_ff      <= doc_in;
      norm_ff     <= norm_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   `DLNE_ASSERT_IMP(a_wr_states, clock, reset, wr_en, state_ff == ST_CLEAR || state_ff == ST_EXEC)
   `DLNE_ASSERT_IMP(a_norm_done_state, clock, reset, norm_rsp.done, state_ff == ST_NORM)
   `DLNE_ASSERT_IMP(a_docs_bound, clock, reset, 1'b1, docs_seen_ff <= DepthVal)
   `DLNE_ASSERT_NXT(a_fin_loads, clock, reset, state_ff == ST_FIN && !rsp_valid_ff, rsp_valid_ff)

endmodule

// ===== tb/doc_length_norm_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doc_length_norm_encoder_tb
// self-checking bench: token record and norm read requests with random
// handshake gaps; a scoreboard keeps its own per-document counts and predicts
// each response, compared field by field against the block's output
// ----------------------------------------------------------------------------
module doc_length_norm_encoder_tb;
   import dlne_pkg::*;

   // request function codes
   localparam logic FUNC_RECORD = 1'b0;
   localparam logic FUNC_READ   = 1'b1;
   // response status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_BEYOND = 1'b1;

   localparam int NUM_DOCS    = 4096;
   localparam int DIRECTED_N  = 15;
   localparam int RANDOM_N    = 1535;
   localparam int DRAIN_WAIT  = 40;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef struct {
      logic [NORM_W-1:0]  norm;
      logic [TOTAL_W-1:0] total;
      logic [DOCS_W-1:0]  docs;
      logic               status;
   } norm_rsp_type;

   // ------------------------------------------------------------------------
   // scoreboard: per-document token counts and queue of pending responses
   // ------------------------------------------------------------------------
   class norm_scoreboard;
      logic [COUNT_W-1:0] doc_counts [NUM_DOCS];
      logic [DOCS_W-1:0]  docs_seen;
      logic [TOTAL_W-1:0] token_sum;
      norm_rsp_type       pending_rsp [$];
      int                 errors;

      function new();
         foreach (doc_counts[d]) doc_counts[d] = '0;
         docs_seen = '0;
         token_sum = '0;
         errors    = 0;
      endfunction

      // small-float length code, offset by the free range, kept to a byte
      function logic [NORM_W-1:0] length_norm(logic [COUNT_W-1:0] len);
         logic [COUNT_W-1:0] excess;
         int nbits;
         int shift;
         int code;
         if (len == 0) return 8'd1;
         if (len < FREE_VALUES_C) return len[NORM_W-1:0];
         excess = len - FREE_VALUES_C;
         nbits = 0;
         for (int b = 0; b < COUNT_W; b++)
            if (excess[b]) nbits = b + 1;
         if (nbits < HEAD_BITS) begin
            code = int'(excess);
         end else begin
            shift = nbits - HEAD_BITS;
            code  = int'((excess >> shift) & 7) | ((shift + 1) << MANT_BITS);
         end
         return NORM_W'(int'(FREE_VALUES) + code);
      endfunction

      // accepted request: update counts and queue the expected response
      function void note_request(logic func, logic [DOC_W-1:0] doc);
         norm_rsp_type rsp;
         rsp.norm   = '0;
         rsp.status = STATUS_OK;
         if (func == FUNC_RECORD) begin
            if (doc_counts[doc] < COUNT_MAX) doc_counts[doc]++;
            if (token_sum < TOTAL_MAX) token_sum++;
            if ({1'b0, doc} + DOCS_W'(1) > docs_seen)
               docs_seen = {1'b0, doc} + DOCS_W'(1);
         end else if ({1'b0, doc} >= docs_seen) begin
            rsp.status = STATUS_BEYOND;
         end else begin
            rsp.norm = length_norm(doc_counts[doc]);
         end
         rsp.total = token_sum;
         rsp.docs  = docs_seen;
         pending_rsp.push_back(rsp);
      endfunction

      // accepted response: compare against the oldest expectation
      function void check_response(logic [71:0] data, logic status);
         norm_rsp_type exp_rsp;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: tdata=%h status=%0d", data, status);
            errors++;
            return;
         end
         exp_rsp = pending_rsp.pop_front();
         if (data[7:0] !== exp_rsp.norm) begin
            $error("norm_byte: expected %0d, got %0d", exp_rsp.norm, data[7:0]);
            errors++;
         end
         if (data[55:8] !== exp_rsp.total) begin
            $error("token_total: expected %0d, got %0d", exp_rsp.total, data[55:8]);
            errors++;
         end
         if (data[68:56] !== exp_rsp.docs) begin
            $error("doc_total: expected %0d, got %0d", exp_rsp.docs, data[68:56]);
            errors++;
         end
         if (status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, status);
            errors++;
         end
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals and block instance
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [11:0] doc_number, [15:12] zero
   logic        req_tuser  = FUNC_RECORD;  // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // [7:0] norm_byte, [55:8] token_total,
                                   // [68:56] doc_total, [71:69] zero
   logic        rsp_tuser;         // [0] status

   norm_scoreboard board = new();
   bit             steady = 1'b0;  // no idling on either side while set

   doc_length_norm_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------------
   // request driver: called at a rising edge, returns at the accepting edge
   // ------------------------------------------------------------------------
   task automatic send_request(input logic func, input logic [DOC_W-1:0] doc);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {4'b0, doc};
      do @(posedge clock); while (!req_tready);
      board.note_request(func, doc);
   endtask

   // ------------------------------------------------------------------------
   // response sink with random stalls
   // ------------------------------------------------------------------------
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      logic             dir_func [DIRECTED_N];
      logic [DOC_W-1:0] dir_doc  [DIRECTED_N];
      logic [DOC_W-1:0] hot_doc  [4];
      logic             func;
      logic [DOC_W-1:0] doc;
      int               pick;

      // reads before any record, first records, empty doc inside the count,
      // reads past the count
      dir_func = '{FUNC_READ, FUNC_READ, FUNC_RECORD, FUNC_READ, FUNC_RECORD,
                   FUNC_READ, FUNC_READ, FUNC_RECORD, FUNC_READ, FUNC_READ,
                   FUNC_READ, FUNC_RECORD, FUNC_RECORD, FUNC_READ, FUNC_READ};
      dir_doc  = '{12'd0, 12'd4095, 12'd0, 12'd0, 12'd0,
                   12'd0, 12'd1, 12'd2047, 12'd1, 12'd2047,
                   12'd2048, 12'd5, 12'd5, 12'd5, 12'd4095};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < DIRECTED_N; k++)
         send_request(dir_func[k], dir_doc[k]);

      // a few documents take most records so lengths pass the free range
      foreach (hot_doc[h]) hot_doc[h] = DOC_W'($urandom_range(0, 2047));

      for (int k = 0; k < RANDOM_N; k++) begin
         if (k % 100 == 0) steady = ($urandom_range(0, 3) == 0);

         // hold off once until every response is back
         if (k == RANDOM_N / 2) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (board.pending() != 0);
         end

         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            func = FUNC_RECORD;
            pick = $urandom_range(0, 99);
            if (pick < 45)      doc = hot_doc[0];
            else if (pick < 60) doc = hot_doc[1];
            else if (pick < 68) doc = hot_doc[2];
            else if (pick < 75) doc = hot_doc[3];
            // full range only late, so reads past the count stay reachable
            else if (k < RANDOM_N / 2) doc = DOC_W'($urandom_range(0, 2047));
            else                       doc = DOC_W'($urandom_range(0, 4095));
         end else begin
            func = FUNC_READ;
            pick = $urandom_range(0, 99);
            if (pick < 60) doc = hot_doc[$urandom_range(0, 3)];
            else if (pick < 75) doc = DOC_W'($urandom_range(0, 63));
            else doc = DOC_W'($urandom_range(0, 4095));
         end
         send_request(func, doc);
      end

      // drain
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
